[src/bptc_pkg.sv]
// ----------------------------------------------------------------------------
// bptc_pkg
// Shared types, register indexes and 32-bit wrap arithmetic helpers for the
// barometer temperature and pressure compensation pipeline.
// ----------------------------------------------------------------------------
package bptc_pkg;

	localparam int DivSteps = 32;

	// configuration register indexes
	localparam logic [2:0] RegOss   = 3'd0;
	localparam logic [2:0] RegCalA  = 3'd1;
	localparam logic [2:0] RegCalB  = 3'd2;
	localparam logic [2:0] RegCalC  = 3'd3;
	localparam logic [2:0] RegCalD  = 3'd4;
	localparam logic [2:0] RegCalE  = 3'd5;

	localparam logic [1:0]  OssReset  = 2'd3;
	localparam logic [31:0] B6Offset  = 32'd4000;
	localparam logic [31:0] B4Offset  = 32'd32768;
	localparam logic [31:0] B7Scale   = 32'd50000;
	localparam logic [31:0] PCoefSq   = 32'd3038;
	localparam logic [31:0] PCoefLin  = 32'hFFFF_E343; // -7357
	localparam logic [31:0] PCoefOfs  = 32'd3791;

	typedef struct packed {
		logic [15:0] raw_temp;
		logic [23:0] raw_pressure;
	} sample_t;

	typedef struct packed {
		logic [31:0] temperature_tenths;
		logic [31:0] pressure_pa;
		logic        div_error;
	} result_t;

	// items riding alongside a divider
	typedef struct packed {
		logic        err;
		logic        neg;
		logic [31:0] a;
		logic [31:0] b;
	} div_side_t;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

	function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] n);
		return $signed(v) >>> n;
	endfunction

	function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = a * b;
		return p[31:0];
	endfunction

endpackage

[src/bptc_div.sv]
// ----------------------------------------------------------------------------
// bptc_div
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bptc_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [31:0]            dividend,
	input  logic [31:0]            divisor,
	input  bptc_pkg::div_side_t    in_side,
	output logic                   out_valid,
	output logic [31:0]            quotient,
	output bptc_pkg::div_side_t    out_side
);

	logic [31:0]         rem_s  [bptc_pkg::DivSteps];
	logic [31:0]         nq_s   [bptc_pkg::DivSteps];
	logic [31:0]         d_s    [bptc_pkg::DivSteps];
	bptc_pkg::div_side_t side_s [bptc_pkg::DivSteps];
	logic                vld_s  [bptc_pkg::DivSteps];

	genvar k;
	generate
		for (k = 0; k < bptc_pkg::DivSteps; k++) begin : g_step
			logic [31:0]         rem_p, nq_p, d_p;
			bptc_pkg::div_side_t side_p;
			logic                vld_p;
			logic [32:0]         r;
			logic                ge;
			logic [32:0]         diff;

			if (k == 0) begin : g_first
				assign rem_p  = '0;
				assign nq_p   = dividend;
				assign d_p    = divisor;
				assign side_p = in_side;
				assign vld_p  = in_valid;
			end else begin : g_next
				assign rem_p  = rem_s[k-1];
				assign nq_p   = nq_s[k-1];
				assign d_p    = d_s[k-1];
				assign side_p = side_s[k-1];
				assign vld_p  = vld_s[k-1];
			end

			assign r    = {rem_p, nq_p[31]};
			assign diff = r - {1'b0, d_p};
			assign ge   = (r >= {1'b0, d_p});

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else if (en) begin
					vld_s[k] <= vld_p;
				end
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k]  <= ge ? diff[31:0] : r[31:0];
					nq_s[k]   <= {nq_p[30:0], ge};
					d_s[k]    <= d_p;
					side_s[k] <= side_p;
				end
			end
		end
	endgenerate

	assign out_valid = vld_s[bptc_pkg::DivSteps-1];
	assign quotient  = nq_s[bptc_pkg::DivSteps-1];
	assign out_side  = side_s[bptc_pkg::DivSteps-1];

endmodule

[src/baro_temp_pressure_compensation_unit.sv]
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_unit
// Integer barometer compensation: raw temperature and pressure in, temperature
// in tenths of a degree and pressure in pascals out.
// ----------------------------------------------------------------------------
// Usage:
//  - sample channel (sample_valid / sample_stall / sample) takes one item per
//    cycle unless stalled: a 16-bit raw temperature and a 24-bit raw pressure.
//  - result channel (result_valid / result_stall / result) returns one item
//    per sample, in order: temperature_tenths, pressure_pa, div_error.
//  - cfg channel writes oversampling (index 0) and the five calibration pairs
//    (indexes 1..5); cfg_ready is always high. Write only while idle.
//  - Depth: 78 register stages. Two 32-stage dividers (temperature x2 term
//    and pressure quotient) set most of it.
//  - Throughput: one item per cycle while not stalled; every stage holds one item.
//  - When result_stall is high with a result waiting, the whole pipeline
//    freezes and sample_stall rises; nothing is dropped or repeated.
//  - Reset clears all valid bits, oversampling to 3, calibration to 0.
//  - A zero divisor gives div_error = 1 with both values forced to 0.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  bptc_pkg::sample_t   sample,
	output logic                result_valid,
	input  logic                result_stall,
	output bptc_pkg::result_t   result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [2:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	// ---------------- configuration registers ----------------
	logic [1:0]  oss_q;
	logic [31:0] cal_a_q, cal_b_q, cal_c_q, cal_d_q, cal_e_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oss_q   <= bptc_pkg::OssReset;
			cal_a_q <= '0;
			cal_b_q <= '0;
			cal_c_q <= '0;
			cal_d_q <= '0;
			cal_e_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bptc_pkg::RegOss:  oss_q   <= cfg_data[1:0];
				bptc_pkg::RegCalA: cal_a_q <= cfg_data;
				bptc_pkg::RegCalB: cal_b_q <= cfg_data;
				bptc_pkg::RegCalC: cal_c_q <= cfg_data;
				bptc_pkg::RegCalD: cal_d_q <= cfg_data;
				bptc_pkg::RegCalE: cal_e_q <= cfg_data;
				default: ; // writes past the register list are dropped
			endcase
		end
	end

	// decoded coefficients, 32-bit
	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1c, b2c, mc, md;
	assign ac1 = bptc_pkg::sx16(cal_a_q[31:16]);
	assign ac2 = bptc_pkg::sx16(cal_a_q[15:0]);
	assign ac3 = bptc_pkg::sx16(cal_b_q[31:16]);
	assign ac4 = {16'd0, cal_b_q[15:0]};
	assign ac5 = {16'd0, cal_c_q[31:16]};
	assign ac6 = {16'd0, cal_c_q[15:0]};
	assign b1c = bptc_pkg::sx16(cal_d_q[31:16]);
	assign b2c = bptc_pkg::sx16(cal_d_q[15:0]);
	assign mc  = bptc_pkg::sx16(cal_e_q[31:16]);
	assign md  = bptc_pkg::sx16(cal_e_q[15:0]);

	// ---------------- global advance ----------------
	// One enable for every stage: the pipeline moves unless a finished
	// result is held by the receiver.
	logic en;
	assign en           = !(result_valid && result_stall);
	assign sample_stall = !en;

	// ---------------- s1: temperature product ----------------
	logic        v_s1;
	logic [31:0] prod_t_s1, up_s1;
	logic [31:0] up_in;
	assign up_in = {8'd0, sample.raw_pressure} >> (4'd8 - {2'd0, oss_q});

	// ---------------- s2: x1 and divider set-up ----------------
	logic        v_s2;
	logic [31:0] dvd1_s2, dvs1_s2;
	bptc_pkg::div_side_t side1_s2;
	logic [31:0] x1_t, den, num_t;
	assign x1_t  = bptc_pkg::asr32(prod_t_s1, 5'd15);
	assign den   = x1_t + md;
	assign num_t = mc << 11;

	// ---------------- divider 1 ----------------
	logic                v_d1;
	logic [31:0]         q_d1;
	bptc_pkg::div_side_t side_d1;

	// ---------------- s3 .. s10 ----------------
	logic        v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic        err_s3, err_s4, err_s5, err_s6, err_s7, err_s8, err_s9;
	logic [31:0] temp_s3, temp_s4, temp_s5, temp_s6, temp_s7, temp_s8, temp_s9;
	logic [31:0] up_s3, up_s4, up_s5, up_s6, up_s7;
	logic [31:0] b6_s3;
	logic [31:0] b6sq_s4, pac2_s4, pac3_s4;
	logic [31:0] sq_s5, x2a_s5, x1c_s5;
	logic [31:0] x2a_s6, x1c_s6, pb2_s6, pb1_s6;
	logic [31:0] b3_s7, t4_s7;
	logic [31:0] b4p_s8, d7_s8;
	logic [31:0] b4_s9, b7_s9;
	logic [31:0] dvd2_s10, dvs2_s10;
	bptc_pkg::div_side_t side2_s10;

	logic [31:0] x2_t, b5;
	assign x2_t = side_d1.neg ? (32'd0 - q_d1) : q_d1;
	assign b5   = side_d1.a + x2_t;

	logic [31:0] x1_s7, x3_s7, b3_pre, x2_s7, x3b_s7;
	assign x1_s7  = bptc_pkg::asr32(pb2_s6, 5'd11);
	assign x3_s7  = x1_s7 + x2a_s6;
	assign b3_pre = ((ac1 << 2) + x3_s7) << oss_q;
	assign x2_s7  = bptc_pkg::asr32(pb1_s6, 5'd16);
	assign x3b_s7 = bptc_pkg::asr32(x1c_s6 + x2_s7 + 32'd2, 5'd2);

	// ---------------- divider 2 ----------------
	logic                v_d2;
	logic [31:0]         q_d2;
	bptc_pkg::div_side_t side_d2;

	// ---------------- s11 .. s14 ----------------
	logic        v_s11, v_s12, v_s13;
	logic        err_s11, err_s12, err_s13;
	logic [31:0] temp_s11, temp_s12, temp_s13;
	logic [31:0] p_s11, p_s12, p_s13;
	logic [31:0] psq_s12, plin_s12;
	logic [31:0] pq_s13, x2p_s13;
	logic [31:0] p8;
	assign p8 = bptc_pkg::asr32(p_s11, 5'd8);

	logic [31:0] x1p, p_fin;
	assign x1p   = bptc_pkg::asr32(pq_s13, 5'd16);
	assign p_fin = p_s13 + bptc_pkg::asr32(x1p + x2p_s13 + bptc_pkg::PCoefOfs, 5'd4);

	logic        v_s14;
	bptc_pkg::result_t res_s14;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0; v_s2  <= 1'b0; v_s3  <= 1'b0; v_s4  <= 1'b0;
			v_s5  <= 1'b0; v_s6  <= 1'b0; v_s7  <= 1'b0; v_s8  <= 1'b0;
			v_s9  <= 1'b0; v_s10 <= 1'b0; v_s11 <= 1'b0; v_s12 <= 1'b0;
			v_s13 <= 1'b0; v_s14 <= 1'b0;
		end else if (en) begin
			v_s1  <= sample_valid;
			v_s2  <= v_s1;
			v_s3  <= v_d1;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_d2;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			// s1
			prod_t_s1 <= bptc_pkg::mul32({16'd0, sample.raw_temp} - ac6, ac5);
			up_s1     <= up_in;
			// s2: signed divide by magnitudes
			dvd1_s2       <= num_t[31] ? (32'd0 - num_t) : num_t;
			dvs1_s2       <= den[31] ? (32'd0 - den) : den;
			side1_s2.err  <= (den == 32'd0);
			side1_s2.neg  <= num_t[31] ^ den[31];
			side1_s2.a    <= x1_t;
			side1_s2.b    <= up_s1;
			// s3
			err_s3  <= side_d1.err;
			temp_s3 <= bptc_pkg::asr32(b5 + 32'd8, 5'd4);
			b6_s3   <= b5 - bptc_pkg::B6Offset;
			up_s3   <= side_d1.b;
			// s4
			err_s4  <= err_s3;
			temp_s4 <= temp_s3;
			up_s4   <= up_s3;
			b6sq_s4 <= bptc_pkg::mul32(b6_s3, b6_s3);
			pac2_s4 <= bptc_pkg::mul32(ac2, b6_s3);
			pac3_s4 <= bptc_pkg::mul32(ac3, b6_s3);
			// s5
			err_s5  <= err_s4;
			temp_s5 <= temp_s4;
			up_s5   <= up_s4;
			sq_s5   <= bptc_pkg::asr32(b6sq_s4, 5'd12);
			x2a_s5  <= bptc_pkg::asr32(pac2_s4, 5'd11);
			x1c_s5  <= bptc_pkg::asr32(pac3_s4, 5'd13);
			// s6
			err_s6  <= err_s5;
			temp_s6 <= temp_s5;
			up_s6   <= up_s5;
			x2a_s6  <= x2a_s5;
			x1c_s6  <= x1c_s5;
			pb2_s6  <= bptc_pkg::mul32(b2c, sq_s5);
			pb1_s6  <= bptc_pkg::mul32(b1c, sq_s5);
			// s7
			err_s7  <= err_s6;
			temp_s7 <= temp_s6;
			up_s7   <= up_s6;
			b3_s7   <= bptc_pkg::asr32(b3_pre + 32'd2, 5'd2);
			t4_s7   <= x3b_s7 + bptc_pkg::B4Offset;
			// s8
			err_s8  <= err_s7;
			temp_s8 <= temp_s7;
			b4p_s8  <= bptc_pkg::mul32(ac4, t4_s7);
			d7_s8   <= up_s7 - b3_s7;
			// s9
			err_s9  <= err_s8;
			temp_s9 <= temp_s8;
			b4_s9   <= b4p_s8 >> 15;
			b7_s9   <= bptc_pkg::mul32(d7_s8, bptc_pkg::B7Scale >> oss_q);
			// s10: large b7 is divided first and doubled after
			dvd2_s10      <= b7_s9[31] ? b7_s9 : (b7_s9 << 1);
			dvs2_s10      <= b4_s9;
			side2_s10.err <= err_s9 || (b4_s9 == 32'd0);
			side2_s10.neg <= b7_s9[31];
			side2_s10.a   <= temp_s9;
			side2_s10.b   <= '0;
			// s11
			err_s11  <= side_d2.err;
			temp_s11 <= side_d2.a;
			p_s11    <= side_d2.neg ? (q_d2 << 1) : q_d2;
			// s12
			err_s12  <= err_s11;
			temp_s12 <= temp_s11;
			p_s12    <= p_s11;
			psq_s12  <= bptc_pkg::mul32(p8, p8);
			plin_s12 <= bptc_pkg::mul32(bptc_pkg::PCoefLin, p_s11);
			// s13
			err_s13  <= err_s12;
			temp_s13 <= temp_s12;
			p_s13    <= p_s12;
			pq_s13   <= bptc_pkg::mul32(psq_s12, bptc_pkg::PCoefSq);
			x2p_s13  <= bptc_pkg::asr32(plin_s12, 5'd16);
			// s14: output register
			res_s14.div_error          <= err_s13;
			res_s14.temperature_tenths <= err_s13 ? 32'd0 : temp_s13;
			res_s14.pressure_pa        <= err_s13 ? 32'd0 : p_fin;
		end
	end

	bptc_div u_div_temp (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.dividend  (dvd1_s2),
		.divisor   (dvs1_s2),
		.in_side   (side1_s2),
		.out_valid (v_d1),
		.quotient  (q_d1),
		.out_side  (side_d1)
	);

	bptc_div u_div_press (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s10),
		.dividend  (dvd2_s10),
		.divisor   (dvs2_s10),
		.in_side   (side2_s10),
		.out_valid (v_d2),
		.quotient  (q_d2),
		.out_side  (side_d2)
	);

	assign result_valid = v_s14;
	assign result       = res_s14;

	// ---------------- assertions ----------------
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.div_error |->
			result.temperature_tenths == 32'd0 && result.pressure_pa == 32'd0)
		else $error("div_error result with nonzero values");

	a_stall_only_held: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> result_valid && result_stall)
		else $error("input stalled without a held result");

	a_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> v_s13 == $past(v_s13) && v_s2 == $past(v_s2))
		else $error("pipeline moved while output held");

endmodule

[sim/bptc_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bptc_result_checker
// Watches the sample, result and config channels of the compensation unit,
// computes the expected compensated temperature and pressure for each
// accepted sample, and compares results in order.
// ----------------------------------------------------------------------------
module bptc_result_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	input  logic               sample_stall,
	input  bptc_pkg::sample_t  sample,
	input  logic               result_valid,
	input  logic               result_stall,
	input  bptc_pkg::result_t  result,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output int                 mismatches,
	output int                 pending,
	output int                 results_seen,
	output int                 div_errors_seen
);

	logic [1:0]        oss;
	logic [31:0]       cal [1:5];
	bptc_pkg::result_t expected_q [$];

	function automatic logic [31:0] sra(input logic [31:0] v, input int n);
		return $signed(v) >>> n;
	endfunction

	function automatic logic [31:0] sq32(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = a * b;
		return p[31:0];
	endfunction

	function automatic logic [31:0] signed_quot(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] ma, mb, q;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		return (a[31] != b[31]) ? -q : q;
	endfunction

	function automatic bptc_pkg::result_t compensate(input bptc_pkg::sample_t s);
		bptc_pkg::result_t r;
		logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
		logic [31:0] ut, up, x1, x2, x3, den, b5, b6, b3, b4, b7, p, sq, t;
		ac1 = {{16{cal[1][31]}}, cal[1][31:16]};
		ac2 = {{16{cal[1][15]}}, cal[1][15:0]};
		ac3 = {{16{cal[2][31]}}, cal[2][31:16]};
		ac4 = {16'd0, cal[2][15:0]};
		ac5 = {16'd0, cal[3][31:16]};
		ac6 = {16'd0, cal[3][15:0]};
		b1  = {{16{cal[4][31]}}, cal[4][31:16]};
		b2  = {{16{cal[4][15]}}, cal[4][15:0]};
		mc  = {{16{cal[5][31]}}, cal[5][31:16]};
		md  = {{16{cal[5][15]}}, cal[5][15:0]};
		ut = {16'd0, s.raw_temp};
		up = {8'd0, s.raw_pressure} >> (8 - oss);
		r = '{temperature_tenths: 32'd0, pressure_pa: 32'd0, div_error: 1'b1};
		x1 = sra(sq32(ut - ac6, ac5), 15);
		den = x1 + md;
		if (den == 0) return r;
		x2 = signed_quot(mc << 11, den);
		b5 = x1 + x2;
		t = sra(b5 + 8, 4);
		b6 = b5 - 32'd4000;
		sq = sra(sq32(b6, b6), 12);
		x1 = sra(sq32(b2, sq), 11);
		x2 = sra(sq32(ac2, b6), 11);
		x3 = x1 + x2;
		b3 = sra(((ac1 * 4 + x3) << oss) + 2, 2);
		x1 = sra(sq32(ac3, b6), 13);
		x2 = sra(sq32(b1, sq), 16);
		x3 = sra(x1 + x2 + 2, 2);
		b4 = sq32(ac4, x3 + 32'd32768) >> 15;
		if (b4 == 0) return r;
		b7 = sq32(up - b3, 32'd50000 >> oss);
		if (!b7[31]) p = (b7 * 2) / b4;
		else p = (b7 / b4) * 2;
		x1 = sq32(sra(p, 8), sra(p, 8));
		x1 = sra(sq32(x1, 32'd3038), 16);
		x2 = sra(sq32(-32'd7357, p), 16);
		p = p + sra(x1 + x2 + 32'd3791, 4);
		r.temperature_tenths = t;
		r.pressure_pa = p;
		r.div_error = 1'b0;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bptc_pkg::result_t want;
		if (!arst_n) begin
			oss <= bptc_pkg::OssReset;
			for (int i = 1; i <= 5; i++) cal[i] <= '0;
			mismatches <= 0;
			results_seen <= 0;
			div_errors_seen <= 0;
			expected_q.delete();
		end else begin
			if (sample_valid && !sample_stall)
				expected_q.push_back(compensate(sample));
			if (result_valid && !result_stall) begin
				results_seen <= results_seen + 1;
				if (result.div_error) div_errors_seen <= div_errors_seen + 1;
				if (expected_q.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("unexpected result %h", result);
				end else begin
					want = expected_q.pop_front();
					if (want !== result) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display("mismatch: exp t=%0d p=%0d e=%b got t=%0d p=%0d e=%b",
								$signed(want.temperature_tenths), $signed(want.pressure_pa),
								want.div_error, $signed(result.temperature_tenths),
								$signed(result.pressure_pa), result.div_error);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == bptc_pkg::RegOss) oss <= cfg_data[1:0];
				else if (cfg_index >= bptc_pkg::RegCalA && cfg_index <= bptc_pkg::RegCalE)
					cal[cfg_index] <= cfg_data;
			end
		end
	end

	assign pending = expected_q.size();

endmodule

[sim/baro_temp_pressure_compensation_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_unit_test
// Drives raw samples and calibration settings into the compensation unit
// with random gaps and stalls; a checker predicts and compares each result.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_unit_test;

	logic              clk;
	logic              arst_n;
	logic              sample_valid;
	logic              sample_stall;
	bptc_pkg::sample_t sample;
	logic              result_valid;
	logic              result_stall;
	bptc_pkg::result_t result;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [2:0]        cfg_index;
	logic [31:0]       cfg_data;
	int        mismatches, pending, results_seen, div_errors_seen;

	// receiver control: random stall bursts, long hold-off, quiet tail
	bit        rx_random;
	bit        rx_hold;
	int        items_sent;

	baro_temp_pressure_compensation_unit dut (.*);

	bptc_result_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// watchdog; slowest run is far below this
	initial begin
		#4_000_000;
		$display("baro_temp_pressure_compensation_unit_test: done, errors");
		$finish;
	end

	// receiver: random stall bursts, or a fixed hold-off when asked
	initial begin
		int n;
		result_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold) begin
				result_stall <= 1'b1;
				repeat (300) @(posedge clk);
				rx_hold = 1'b0;
				result_stall <= 1'b0;
			end else if (rx_random && $urandom_range(0, 3) == 0) begin
				result_stall <= 1'b1;
				n = $urandom_range(1, 8);
				repeat (n - 1) @(posedge clk);
				@(posedge clk);
				result_stall <= 1'b0;
			end else
				result_stall <= 1'b0;
		end
	end

	// one config write; cfg_ready is always high but wait for it anyway
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait until all results are in, then past the pipeline depth
	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// offer one item; optional random gap before it
	task automatic send_item(input logic [15:0] t, input logic [23:0] p, input bit gaps);
		int g;
		if (gaps && $urandom_range(0, 3) == 0) begin
			sample_valid <= 1'b0;
			g = $urandom_range(1, 8);
			repeat (g) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample <= '{raw_temp: t, raw_pressure: p};
		do @(posedge clk); while (sample_stall);
		items_sent++;
	endtask

	// typical datasheet-like calibration, lightly randomized, or fully random when wild
	task automatic load_cal(input logic [1:0] o, input bit wild);
		write_reg(bptc_pkg::RegOss, {30'd0, o});
		if (wild) begin
			write_reg(bptc_pkg::RegCalA, $urandom());
			write_reg(bptc_pkg::RegCalB, $urandom());
			write_reg(bptc_pkg::RegCalC, $urandom());
			write_reg(bptc_pkg::RegCalD, $urandom());
			write_reg(bptc_pkg::RegCalE, $urandom());
		end else begin
			write_reg(bptc_pkg::RegCalA, {16'(408 + $urandom_range(0, 200)), 16'(-72)});
			write_reg(bptc_pkg::RegCalB,
				{16'(-14383), 16'(32741 - $urandom_range(0, 3000))});
			write_reg(bptc_pkg::RegCalC, {16'(32757 - $urandom_range(0, 9000)), 16'd23153});
			write_reg(bptc_pkg::RegCalD, {16'd6190, 16'd4});
			write_reg(bptc_pkg::RegCalE, {16'(-8711), 16'(2868 + $urandom_range(0, 100))});
		end
	endtask

	initial begin
		logic [15:0] t;
		logic [23:0] p;
		sample_valid = 1'b0;
		sample = '0;
		cfg_valid = 1'b0;
		cfg_index = bptc_pkg::RegOss;
		cfg_data = '0;
		rx_random = 1'b0;
		rx_hold = 1'b0;
		items_sent = 0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset calibration: every item hits the zero temperature divisor
		send_item(16'h0000, 24'h000000, 1'b0);
		send_item(16'hFFFF, 24'hFFFFFF, 1'b0);
		sample_valid <= 1'b0;
		drain();

		// directed: field extremes with realistic coefficients, oss 0 and 3
		load_cal(2'd0, 1'b0);
		send_item(16'h0000, 24'h000000, 1'b0);
		send_item(16'hFFFF, 24'hFFFFFF, 1'b0);
		send_item(16'd27898, 24'h5D2300, 1'b0);
		send_item(16'h8000, 24'h800000, 1'b0);
		sample_valid <= 1'b0;
		drain();
		load_cal(2'd3, 1'b0);
		send_item(16'h0000, 24'hFFFFFF, 1'b0);
		send_item(16'hFFFF, 24'h000000, 1'b0);
		send_item(16'd27898, 24'h5D23A0, 1'b0);
		sample_valid <= 1'b0;
		drain();

		// zero pressure divisor: ac4 = 0
		write_reg(bptc_pkg::RegCalB, {16'(-14383), 16'd0});
		send_item(16'd27898, 24'h5D23A0, 1'b0);
		sample_valid <= 1'b0;
		drain();

		// zero temperature divisor with nonzero x1: ac5 = 32768, ac6 = 0,
		// md = -(ut/1) so x1 + md = 0 at ut = 100
		write_reg(bptc_pkg::RegCalB, {16'(-14383), 16'd32741});
		write_reg(bptc_pkg::RegCalC, {16'd32768, 16'd0});
		write_reg(bptc_pkg::RegCalE, {16'(-8711), 16'(-100)});
		send_item(16'd100, 24'h123456, 1'b0);
		send_item(16'd101, 24'h123456, 1'b0);
		sample_valid <= 1'b0;
		drain();

		// signed quotient overflow: mc<<11 = -2^31 needs mc = -2^20; not
		// reachable from 16 bits, so push extreme mc/md ratios instead
		write_reg(bptc_pkg::RegCalC, {16'd1, 16'd0});
		write_reg(bptc_pkg::RegCalE, {16'h8000, 16'hFFFF});
		send_item(16'd0, 24'hABCDEF, 1'b0);
		send_item(16'd1, 24'hABCDEF, 1'b0);
		sample_valid <= 1'b0;
		drain();

		// random phases with varied settings, extremes among them
		rx_random = 1'b1;
		for (int ph = 0; ph < 8; ph++) begin
			load_cal(2'($urandom_range(0, 3)), ph % 3 == 2);
			if (ph == 2) rx_hold = 1'b1; // receiver holds off; input must back up
			for (int i = 0; i < 65; i++) begin
				t = (ph % 3 == 2) ? 16'($urandom()) : 16'($urandom_range(20000, 35000));
				p = ($urandom_range(0, 4) == 0) ? 24'($urandom())
					: 24'($urandom_range(24'h400000, 24'h700000));
				send_item(t, p, 1'b1);
			end
			// sender pauses until all results are back
			sample_valid <= 1'b0;
			drain();
		end

		// tail: no idling on either side
		rx_random = 1'b0;
		load_cal(2'd1, 1'b0);
		for (int i = 0; i < 60; i++)
			send_item(16'($urandom()), 24'($urandom()), 1'b0);
		sample_valid <= 1'b0;
		drain();

		$display("covered %0d samples, %0d results, %0d with a zero divisor",
			items_sent, results_seen, div_errors_seen);
		if (mismatches == 0 && pending == 0)
			$display("baro_temp_pressure_compensation_unit_test: done, clean");
		else
			$display("baro_temp_pressure_compensation_unit_test: done, errors");
		$finish;
	end

endmodule
